>>> rtl/vn4_pkg.sv
// shared types, constants and codes of the 4d value-noise sampler
package vn4_pkg;

    // table geometry and fixed-point format
    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 24;
    localparam int TIDX_W     = 8;
    localparam int VAL_W      = 16;
    localparam int PERM_W     = 8;
    localparam int RES_W      = 17;
    localparam int PROD_W     = VAL_W + FRAC_BITS + 2;

    // pipeline depth: input, four permutation levels, noise read, four blend levels
    localparam int NST = 14;

    // one in q.15
    localparam logic [RES_W-1:0] ONE_Q15 = RES_W'(32768);

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [FRAC_BITS-1:0]     frac_t;
    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic [PERM_W-1:0]        perm_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [RES_W-1:0]         res_t;

    typedef enum logic [1:0] {
        CMD_LOAD_NOISE = 2'd0,
        CMD_LOAD_PERM  = 2'd1,
        CMD_EVAL       = 2'd2,
        CMD_TIME       = 2'd3
    } cmd_t;

    // per-item control and payload that travels down the pipeline
    typedef struct packed {
        cmd_t  cmd;
        idx_t  ix;
        idx_t  iy;
        idx_t  iz;
        idx_t  it;
        frac_t fx;
        frac_t fy;
        frac_t fz;
        frac_t ft;
        idx_t  tidx;
        val_t  tval;
        perm_t pt0;
    } ctl_t;

    // lattice coordinate plus step plus permutation entry, modulo the table size
    function automatic idx_t wrap_add(idx_t base, logic step, perm_t entry);
        return idx_t'(base + idx_t'(step) + idx_t'(entry));
    endfunction

endpackage

>>> rtl/vn4_if.sv
// valid/ready channel interfaces for sample requests and results
interface vn4_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [vn4_pkg::COORD_W-1:0]   coord_x;
    logic [vn4_pkg::COORD_W-1:0]   coord_y;
    logic [vn4_pkg::COORD_W-1:0]   coord_z;
    logic [vn4_pkg::COORD_W-1:0]   coord_t;
    logic [vn4_pkg::TIDX_W-1:0]    table_index;
    logic signed [vn4_pkg::VAL_W-1:0] table_value;

    modport source (output valid, cmd, coord_x, coord_y, coord_z, coord_t,
                    table_index, table_value, input ready);
    modport sink   (input valid, cmd, coord_x, coord_y, coord_z, coord_t,
                    table_index, table_value, output ready);
endinterface

interface vn4_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [vn4_pkg::RES_W-1:0]    result_value;

    modport source (output valid, result_value, input ready);
    modport sink   (input valid, result_value, output ready);
endinterface

>>> rtl/vn4_ram.sv
// generic ram: one write port, two registered read ports
module vn4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read ports, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0_reg <= mem_reg[raddr0];
            rdata1_reg <= mem_reg[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

>>> rtl/value_noise_4d_sampler_top.sv
// top level of the 4d value-noise sampler: lookup and blend pipeline
//
//   port  | dir  | transfer             | payload
//   ------+------+----------------------+----------------------------------------
//   req   | sink | valid && ready       | cmd, coord_x/y/z/t, table_index/value
//   rsp   | src  | valid && ready       | result_value
//
// 14 register stages, one item per cycle while rsp is not stalled.
// every lookup level has its own ram copies, written when a load reaches that
// level, so loads and reads stay in item order; the blends take two stages each.
// reset clears the stage valid bits only; table contents are undefined until loaded.
// a stall on rsp freezes the whole pipeline; req.ready drops only while a result waits.
module value_noise_4d_sampler_top (
    input  logic      clk,
    input  logic      rst_n,
    vn4_req_if.sink   req,
    vn4_rsp_if.source rsp
);

    localparam int NST = vn4_pkg::NST;

    logic             en;
    logic [NST-1:0]   vld_reg;
    vn4_pkg::ctl_t    ctl_reg  [NST];
    vn4_pkg::ctl_t    ctl_next [NST];

    logic             wr_perm  [4];
    logic             wr_noise;

    vn4_pkg::idx_t    pt_addr [2];
    vn4_pkg::perm_t   pt_rd   [2];
    vn4_pkg::idx_t    pz_addr [4];
    vn4_pkg::perm_t   pz_rd   [4];
    vn4_pkg::idx_t    py_addr [8];
    vn4_pkg::perm_t   py_rd   [8];
    vn4_pkg::idx_t    px_addr [16];
    vn4_pkg::perm_t   px_rd   [16];
    vn4_pkg::idx_t    n_addr  [16];
    logic [vn4_pkg::VAL_W-1:0] n_rd [16];

    vn4_pkg::val_t    src_a    [4][8];
    vn4_pkg::val_t    src_b    [4][8];
    vn4_pkg::frac_t   wgt      [4];
    vn4_pkg::prod_t   prod_next[4][8];
    vn4_pkg::val_t    a_reg    [4][8];
    vn4_pkg::prod_t   prod_reg [4][8];
    vn4_pkg::val_t    sum_next [3][8];
    vn4_pkg::val_t    sum_reg  [3][8];
    vn4_pkg::val_t    fin_val;
    vn4_pkg::res_t    res_next;
    vn4_pkg::res_t    res_reg;

    // pipeline advance
    assign en        = !vld_reg[NST-1] || rsp.ready;
    assign req.ready = en;

    // input capture; time items get zero weights so blends pass corner zero
    always_comb
    begin
        ctl_next[0].cmd  = vn4_pkg::cmd_t'(req.cmd);
        ctl_next[0].ix   = vn4_pkg::idx_t'(req.coord_x >> vn4_pkg::FRAC_BITS);
        ctl_next[0].iy   = vn4_pkg::idx_t'(req.coord_y >> vn4_pkg::FRAC_BITS);
        ctl_next[0].iz   = vn4_pkg::idx_t'(req.coord_z >> vn4_pkg::FRAC_BITS);
        ctl_next[0].it   = vn4_pkg::idx_t'(req.coord_t >> vn4_pkg::FRAC_BITS);
        ctl_next[0].fx   = req.coord_x[vn4_pkg::FRAC_BITS-1:0];
        ctl_next[0].fy   = req.coord_y[vn4_pkg::FRAC_BITS-1:0];
        ctl_next[0].fz   = req.coord_z[vn4_pkg::FRAC_BITS-1:0];
        ctl_next[0].ft   = req.coord_t[vn4_pkg::FRAC_BITS-1:0];
        ctl_next[0].tidx = vn4_pkg::idx_t'(req.table_index);
        ctl_next[0].tval = req.table_value;
        ctl_next[0].pt0  = '0;
        if (vn4_pkg::cmd_t'(req.cmd) == vn4_pkg::CMD_TIME)
        begin
            ctl_next[0].fx = '0;
            ctl_next[0].fy = '0;
            ctl_next[0].fz = '0;
            ctl_next[0].ft = '0;
        end
        for (int s = 1; s < NST; s++)
        begin
            ctl_next[s] = ctl_reg[s-1];
        end
        // keep perm[t] for the time factor
        ctl_next[2].pt0 = pt_rd[0];
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], req.valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
            begin
                ctl_reg[s] <= ctl_next[s];
            end
        end
    end

    // table writes at the level that reads each copy
    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            wr_perm[s] = en && vld_reg[s] && (ctl_reg[s].cmd == vn4_pkg::CMD_LOAD_PERM);
        end
        wr_noise = en && vld_reg[4] && (ctl_reg[4].cmd == vn4_pkg::CMD_LOAD_NOISE);
    end

    // lookup addresses, chained t, z, y, x
    always_comb
    begin
        pt_addr[0] = ctl_reg[0].it;
        pt_addr[1] = vn4_pkg::wrap_add(ctl_reg[0].it, 1'b1, '0);
        for (int j = 0; j < 4; j++)
        begin
            pz_addr[j] = vn4_pkg::wrap_add(ctl_reg[1].iz, 1'((j & 1)), pt_rd[j >> 1]);
        end
        for (int j = 0; j < 8; j++)
        begin
            py_addr[j] = vn4_pkg::wrap_add(ctl_reg[2].iy, 1'((j & 1)), pz_rd[j >> 1]);
        end
        for (int j = 0; j < 16; j++)
        begin
            px_addr[j] = vn4_pkg::wrap_add(ctl_reg[3].ix, 1'((j & 1)), py_rd[j >> 1]);
        end
        for (int j = 0; j < 16; j++)
        begin
            n_addr[j] = vn4_pkg::idx_t'(px_rd[j]);
        end
        if (ctl_reg[4].cmd == vn4_pkg::CMD_TIME)
        begin
            n_addr[0] = vn4_pkg::idx_t'(ctl_reg[4].pt0);
        end
    end

    // permutation level t
    vn4_ram #(.WIDTH(vn4_pkg::PERM_W), .DEPTH(vn4_pkg::TABLE_SIZE)) u_pt_ram (
        .clk    (clk),
        .we     (wr_perm[0]),
        .waddr  (ctl_reg[0].tidx),
        .wdata  (vn4_pkg::perm_t'(ctl_reg[0].tval)),
        .re     (en),
        .raddr0 (pt_addr[0]),
        .raddr1 (pt_addr[1]),
        .rdata0 (pt_rd[0]),
        .rdata1 (pt_rd[1])
    );

    // permutation level z
    for (genvar c = 0; c < 2; c++)
    begin : g_pz
        vn4_ram #(.WIDTH(vn4_pkg::PERM_W), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
            .clk    (clk),
            .we     (wr_perm[1]),
            .waddr  (ctl_reg[1].tidx),
            .wdata  (vn4_pkg::perm_t'(ctl_reg[1].tval)),
            .re     (en),
            .raddr0 (pz_addr[2*c]),
            .raddr1 (pz_addr[2*c+1]),
            .rdata0 (pz_rd[2*c]),
            .rdata1 (pz_rd[2*c+1])
        );
    end

    // permutation level y
    for (genvar c = 0; c < 4; c++)
    begin : g_py
        vn4_ram #(.WIDTH(vn4_pkg::PERM_W), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
            .clk    (clk),
            .we     (wr_perm[2]),
            .waddr  (ctl_reg[2].tidx),
            .wdata  (vn4_pkg::perm_t'(ctl_reg[2].tval)),
            .re     (en),
            .raddr0 (py_addr[2*c]),
            .raddr1 (py_addr[2*c+1]),
            .rdata0 (py_rd[2*c]),
            .rdata1 (py_rd[2*c+1])
        );
    end

    // permutation level x
    for (genvar c = 0; c < 8; c++)
    begin : g_px
        vn4_ram #(.WIDTH(vn4_pkg::PERM_W), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
            .clk    (clk),
            .we     (wr_perm[3]),
            .waddr  (ctl_reg[3].tidx),
            .wdata  (vn4_pkg::perm_t'(ctl_reg[3].tval)),
            .re     (en),
            .raddr0 (px_addr[2*c]),
            .raddr1 (px_addr[2*c+1]),
            .rdata0 (px_rd[2*c]),
            .rdata1 (px_rd[2*c+1])
        );
    end

    // noise values of the 16 corners
    for (genvar c = 0; c < 8; c++)
    begin : g_noise
        vn4_ram #(.WIDTH(vn4_pkg::VAL_W), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
            .clk    (clk),
            .we     (wr_noise),
            .waddr  (ctl_reg[4].tidx),
            .wdata  (ctl_reg[4].tval),
            .re     (en),
            .raddr0 (n_addr[2*c]),
            .raddr1 (n_addr[2*c+1]),
            .rdata0 (n_rd[2*c]),
            .rdata1 (n_rd[2*c+1])
        );
    end

    // blend operands and weights per level: x, y, z, t
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            src_a[0][j] = $signed(n_rd[2*j]);
            src_b[0][j] = $signed(n_rd[2*j+1]);
        end
        for (int l = 1; l < 4; l++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                if (j < 4)
                begin
                    src_a[l][j] = sum_reg[l-1][2*j];
                    src_b[l][j] = sum_reg[l-1][2*j+1];
                end
                else
                begin
                    src_a[l][j] = '0;
                    src_b[l][j] = '0;
                end
            end
        end
        wgt[0] = ctl_reg[5].fx;
        wgt[1] = ctl_reg[7].fy;
        wgt[2] = ctl_reg[9].fz;
        wgt[3] = ctl_reg[11].ft;
    end

    // multiply half of each blend: (b - a) * w, operands widened to the product
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                prod_next[l][j] = (vn4_pkg::prod_t'(src_b[l][j])
                                   - vn4_pkg::prod_t'(src_a[l][j]))
                                  * vn4_pkg::prod_t'({1'b0, wgt[l]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                for (int j = 0; j < 8; j++)
                begin
                    a_reg[l][j]    <= src_a[l][j];
                    prod_reg[l][j] <= prod_next[l][j];
                end
            end
        end
    end

    // add half of each blend: a + floor(p / 2^frac)
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                sum_next[l][j] = vn4_pkg::val_t'(a_reg[l][j]
                    + vn4_pkg::val_t'(prod_reg[l][j] >>> vn4_pkg::FRAC_BITS));
            end
        end
        fin_val = vn4_pkg::val_t'(a_reg[3][0]
            + vn4_pkg::val_t'(prod_reg[3][0] >>> vn4_pkg::FRAC_BITS));
        case (ctl_reg[12].cmd)
            vn4_pkg::CMD_EVAL:
            begin
                res_next = vn4_pkg::res_t'(fin_val);
            end
            vn4_pkg::CMD_TIME:
            begin
                res_next = vn4_pkg::res_t'(vn4_pkg::ONE_Q15 + vn4_pkg::res_t'(fin_val));
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                for (int j = 0; j < 8; j++)
                begin
                    sum_reg[l][j] <= sum_next[l][j];
                end
            end
            res_reg <= res_next;
        end
    end

    // result channel
    assign rsp.valid        = vld_reg[NST-1];
    assign rsp.result_value = $signed(res_reg);

`ifndef SYNTHESIS
    // a frozen pipeline keeps its valid bits
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("stage valid bits changed during a stall");

    // loads answer zero
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (ctl_reg[NST-1].cmd == vn4_pkg::CMD_LOAD_NOISE
                       || ctl_reg[NST-1].cmd == vn4_pkg::CMD_LOAD_PERM))
        |-> (rsp.result_value == '0))
        else $error("load item gave a nonzero result");

    // time factor lies in 0..65535
    a_time_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && ctl_reg[NST-1].cmd == vn4_pkg::CMD_TIME)
        |-> !rsp.result_value[vn4_pkg::RES_W-1])
        else $error("time factor out of range");
`endif

endmodule
